/* src/ppid_pkg.sv */
// Shared types, constants and defaults for the pulse peak interval detector.
`default_nettype none

package ppid_pkg;

  localparam int WINDOW_TAPS_DEF   = 17;
  localparam int HISTORY_DEPTH_DEF = 20;
  localparam int SAMPLE_BITS_DEF   = 12;

  localparam int SAMPLE_FIELD_W = 12;
  localparam int SLOPE_W        = 17;
  localparam int INTERVAL_W     = 16;
  localparam int LEVEL_W        = 10;
  localparam int CNT_W          = 11;
  localparam int QUOT_W         = 11;
  localparam int CFG_DATA_W     = 11;

  localparam int DIVISOR = 100;

  localparam logic [CNT_W-1:0]      CNT11_MAX = 11'd2047;
  localparam logic [INTERVAL_W-1:0] CNT16_MAX = 16'd65535;
  localparam logic [QUOT_W-1:0]     QUOT_SAT  = 11'd1024;

  localparam logic [CNT_W-1:0]          MIN_GAP_RST  = 11'd300;
  localparam logic [CNT_W-1:0]          TIMEOUT_RST  = 11'd1000;
  localparam logic signed [LEVEL_W-1:0] REARM_RST    = 10'sd250;
  localparam logic signed [LEVEL_W-1:0] BASELINE_RST = 10'sd320;

  typedef enum logic [1:0] {
    CFG_MIN_GAP  = 2'd0,
    CFG_TIMEOUT  = 2'd1,
    CFG_REARM    = 2'd2,
    CFG_BASELINE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0]          min_gap;
    logic [CNT_W-1:0]          timeout;
    logic signed [LEVEL_W-1:0] rearm_lvl;
    logic signed [LEVEL_W-1:0] base_lvl;
  } cfg_t;

  // slope stage result handed to the tracker
  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic [QUOT_W-1:0]  quot;
  } slope_t;

endpackage

`default_nettype wire

/* src/ppid_slope.sv */
// Input register, moving sum, sum delay line, slope and slope/100 pipeline.
`default_nettype none

module ppid_slope #(
  parameter int WINDOW_TAPS   = ppid_pkg::WINDOW_TAPS_DEF,
  parameter int HISTORY_DEPTH = ppid_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = ppid_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [ppid_pkg::SAMPLE_FIELD_W-1:0] sample_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output ppid_pkg::slope_t                         out_o
);

  localparam int SumW   = SAMPLE_BITS + $clog2(WINDOW_TAPS);
  localparam int DivK   = SumW + 7;
  localparam int RecipW = SumW + 1;
  localparam int ProdW  = SumW + RecipW;
  localparam logic [63:0] RecipWide =
    ((64'd1 << DivK) + 64'(ppid_pkg::DIVISOR - 1)) / 64'(ppid_pkg::DIVISOR);
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipWide);

  logic                   s1_v_q, s2_v_q, s3_v_q;
  logic                   s1_ready, s2_ready, s3_ready;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic [SumW-1:0]        s2_slope_q;
  ppid_pkg::slope_t       s3_q;

  logic [SAMPLE_BITS-1:0] raw_q  [WINDOW_TAPS];
  logic [SumW-1:0]        hist_q [HISTORY_DEPTH];
  logic [SumW-1:0]        sum_q;

  logic [31:0]            field_wide;
  logic [SumW-1:0]        sum_d, old_sum, slope_d;
  logic [ProdW-1:0]       prod;
  logic [31:0]            quot_wide;
  logic [63:0]            slope_wide;
  ppid_pkg::slope_t       s3_d;

  assign s3_ready   = !s3_v_q || out_ready_i;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign field_wide = 32'(sample_i);

  always_comb begin
    sum_d   = sum_q - SumW'(raw_q[WINDOW_TAPS-1]) + SumW'(s1_sample_q);
    old_sum = hist_q[HISTORY_DEPTH-1];
    slope_d = (old_sum > sum_d) ? (old_sum - sum_d) : (sum_d - old_sum);
  end

  always_comb begin
    prod       = ProdW'(s2_slope_q) * ProdW'(Recip);
    quot_wide  = 32'(prod[ProdW-1:DivK]);
    slope_wide = 64'(s2_slope_q);
    s3_d.slope = slope_wide[ppid_pkg::SLOPE_W-1:0];
    s3_d.quot  = (quot_wide > 32'(ppid_pkg::QUOT_SAT)) ? ppid_pkg::QUOT_SAT
                                                       : quot_wide[ppid_pkg::QUOT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q <= in_valid_i;
      if (s2_ready) s2_v_q <= s1_v_q;
      if (s3_ready) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) s1_sample_q <= field_wide[SAMPLE_BITS-1:0];
    if (s3_ready && s2_v_q)     s3_q        <= s3_d;
    if (s2_ready && s1_v_q)     s2_slope_q  <= slope_d;
  end

  // delay lines advance once per consumed sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      for (int i = 0; i < WINDOW_TAPS; i++) raw_q[i] <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
    end else if (s2_ready && s1_v_q) begin
      sum_q    <= sum_d;
      raw_q[0] <= s1_sample_q;
      for (int i = 1; i < WINDOW_TAPS; i++) raw_q[i] <= raw_q[i-1];
      hist_q[0] <= sum_d;
      for (int i = 1; i < HISTORY_DEPTH; i++) hist_q[i] <= hist_q[i-1];
    end
  end

  assign out_valid_o = s3_v_q;
  assign out_o       = s3_q;

endmodule

`default_nettype wire

/* src/ppid_tracker.sv */
// Two-phase lowest-level tracker with beat report and result register.
`default_nettype none

module ppid_tracker (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire ppid_pkg::cfg_t                         cfg_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire ppid_pkg::slope_t                       in_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [ppid_pkg::SLOPE_W-1:0]                slope_o,
  output logic                                        beat_valid_o,
  output logic [ppid_pkg::INTERVAL_W-1:0]             beat_interval_o,
  output logic signed [ppid_pkg::LEVEL_W-1:0]         beat_level_o,
  output logic                                        noise_rearm_o
);

  logic                                   fire;
  logic                                   out_v_q;

  logic [ppid_pkg::CNT_W-1:0]             quiet_q, quiet_d;
  logic [ppid_pkg::CNT_W-1:0]             gap_q, gap_d;
  logic [ppid_pkg::INTERVAL_W-1:0]        intv_q, intv_d;
  logic signed [ppid_pkg::LEVEL_W-1:0]    low_q, low_d;
  logic signed [ppid_pkg::LEVEL_W-1:0]    held_q, held_d;
  logic                                   phase_q, phase_d;

  logic signed [ppid_pkg::LEVEL_W+1:0]    level_full;
  logic signed [ppid_pkg::LEVEL_W-1:0]    level;
  logic                                   beat_d, noise_d;
  logic [ppid_pkg::INTERVAL_W-1:0]        rep_intv_d;
  logic signed [ppid_pkg::LEVEL_W-1:0]    rep_lvl_d;

  assign in_ready_o = !out_v_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    level_full = {{2{cfg_i.base_lvl[ppid_pkg::LEVEL_W-1]}}, cfg_i.base_lvl}
               - $signed({1'b0, in_i.quot});
    if (level_full < -12'sd512) begin
      level = -10'sd512;
    end else if (level_full > 12'sd511) begin
      level = 10'sd511;
    end else begin
      level = level_full[ppid_pkg::LEVEL_W-1:0];
    end
  end

  always_comb begin
    quiet_d    = (quiet_q != ppid_pkg::CNT11_MAX) ? quiet_q + 11'd1 : quiet_q;
    gap_d      = (gap_q != ppid_pkg::CNT11_MAX) ? gap_q + 11'd1 : gap_q;
    intv_d     = intv_q;
    low_d      = low_q;
    held_d     = held_q;
    phase_d    = phase_q;
    beat_d     = 1'b0;
    noise_d    = 1'b0;
    rep_intv_d = '0;
    rep_lvl_d  = '0;
    if (quiet_d > cfg_i.timeout) begin
      low_d   = cfg_i.base_lvl;
      phase_d = 1'b0;
      gap_d   = '0;
      quiet_d = '0;
      intv_d  = '0;
      noise_d = 1'b1;
    end else begin
      if (level < low_d) begin
        low_d   = level;
        quiet_d = '0;
        if (!phase_d) begin
          gap_d  = '0;
          intv_d = '0;
        end
      end
      if (gap_d > cfg_i.min_gap && !phase_d) begin
        held_d  = low_d;
        low_d   = cfg_i.rearm_lvl;
        gap_d   = '0;
        phase_d = 1'b1;
      end
      if (gap_d > cfg_i.min_gap && phase_d) begin
        beat_d     = 1'b1;
        rep_intv_d = intv_d;
        rep_lvl_d  = held_d;
        held_d     = '0;
        low_d      = cfg_i.base_lvl;
        phase_d    = 1'b0;
        gap_d      = '0;
        quiet_d    = '0;
        intv_d     = '0;
      end
    end
    if (intv_d != ppid_pkg::CNT16_MAX) intv_d = intv_d + 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_q <= '0;
      gap_q   <= '0;
      intv_q  <= '0;
      low_q   <= ppid_pkg::BASELINE_RST;
      held_q  <= '0;
      phase_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) out_v_q <= in_valid_i;
      if (fire) begin
        quiet_q <= quiet_d;
        gap_q   <= gap_d;
        intv_q  <= intv_d;
        low_q   <= low_d;
        held_q  <= held_d;
        phase_q <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      slope_o         <= in_i.slope;
      beat_valid_o    <= beat_d;
      beat_interval_o <= rep_intv_d;
      beat_level_o    <= rep_lvl_d;
      noise_rearm_o   <= noise_d;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

`default_nettype wire

/* src/pulse_peak_interval_detector.sv */
// Top level of the pulse peak interval detector: config registers and pipeline.
//
// Usage:
//   s_axis carries one converter sample per request (tdata[11:0]); m_axis returns
//   one result per sample with the 20-sample slope of the 17-sample moving sum,
//   a beat report (interval in samples and captured level) and a noise rearm flag.
//   Config registers are written through cfg_we_i / cfg_index_i / cfg_data_i
//   while no sample is in flight; a write takes effect at the next edge.
// Timing:
//   A result passes the input register, slope register, divide register and result
//   register after its sample is accepted. One sample per cycle is sustained while
//   m_axis_tready stays high; the moving-sum update and the tracker state update
//   each close combinationally ahead of their registers.
// Reset:
//   rst_ni clears the delay lines, moving sum, tracker and pipeline, and loads
//   the config registers with their defaults.
// Stall:
//   While m_axis_tready is low the result holds; empty stages still fill, and
//   s_axis_tready drops once every stage holds a sample.
`default_nettype none

module pulse_peak_interval_detector #(
  parameter int WINDOW_TAPS   = ppid_pkg::WINDOW_TAPS_DEF,
  parameter int HISTORY_DEPTH = ppid_pkg::HISTORY_DEPTH_DEF,
  parameter int SAMPLE_BITS   = ppid_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [15:0]                     s_axis_tdata,  // sample[11:0]
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [47:0]                          m_axis_tdata,  // slope, beat_interval, beat_level
  output logic [1:0]                           m_axis_tuser,  // beat_valid, noise_rearm
  input  wire logic                            cfg_we_i,
  input  wire logic [1:0]                      cfg_index_i,
  input  wire logic [ppid_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ppid_pkg::cfg_t                          cfg_q;
  ppid_pkg::slope_t                        slope_s;
  logic                                    slope_valid, slope_ready;
  logic [ppid_pkg::SLOPE_W-1:0]            res_slope;
  logic                                    res_beat, res_noise;
  logic [ppid_pkg::INTERVAL_W-1:0]         res_intv;
  logic signed [ppid_pkg::LEVEL_W-1:0]     res_lvl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_gap   <= ppid_pkg::MIN_GAP_RST;
      cfg_q.timeout   <= ppid_pkg::TIMEOUT_RST;
      cfg_q.rearm_lvl <= ppid_pkg::REARM_RST;
      cfg_q.base_lvl  <= ppid_pkg::BASELINE_RST;
    end else if (cfg_we_i) begin
      unique case (ppid_pkg::cfg_idx_e'(cfg_index_i))
        ppid_pkg::CFG_MIN_GAP:  cfg_q.min_gap   <= cfg_data_i;
        ppid_pkg::CFG_TIMEOUT:  cfg_q.timeout   <= cfg_data_i;
        ppid_pkg::CFG_REARM:    cfg_q.rearm_lvl <= cfg_data_i[ppid_pkg::LEVEL_W-1:0];
        ppid_pkg::CFG_BASELINE: cfg_q.base_lvl  <= cfg_data_i[ppid_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  ppid_slope #(
    .WINDOW_TAPS  (WINDOW_TAPS),
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_slope (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sample_i   (s_axis_tdata[ppid_pkg::SAMPLE_FIELD_W-1:0]),
    .out_valid_o(slope_valid),
    .out_ready_i(slope_ready),
    .out_o      (slope_s)
  );

  ppid_tracker u_tracker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (slope_valid),
    .in_ready_o     (slope_ready),
    .in_i           (slope_s),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .slope_o        (res_slope),
    .beat_valid_o   (res_beat),
    .beat_interval_o(res_intv),
    .beat_level_o   (res_lvl),
    .noise_rearm_o  (res_noise)
  );

  assign m_axis_tdata = {5'd0, res_lvl, res_intv, res_slope};
  assign m_axis_tuser = {res_noise, res_beat};

`ifndef SYNTH
  a_beat_noise_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("beat and noise rearm in the same result");

  a_beat_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[42:17] == 26'd0))
    else $error("beat fields nonzero without a beat");

  a_cfg_min_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_index_i == ppid_pkg::CFG_MIN_GAP) |=>
      (cfg_q.min_gap == $past(cfg_data_i)))
    else $error("min gap write lost");
`endif

endmodule

`default_nettype wire

/* tb/sv/ppid_result_checker.sv */
// Result checker for the pulse peak interval detector: tracks the stream, predicts, compares.
`timescale 1ns / 100ps

module ppid_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // sample[11:0]
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [47:0]                     m_axis_tdata,  // slope, beat_interval, beat_level
  input  logic [1:0]                      m_axis_tuser,  // beat_valid, noise_rearm
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [ppid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              pending_o,
  output int                              fail_count_o
);
  import ppid_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [SLOPE_W-1:0]    slope;
    logic                  beat_valid;
    logic [INTERVAL_W-1:0] beat_interval;
    logic [LEVEL_W-1:0]    beat_level;
    logic                  noise_rearm;
  } ppid_result_t;

  cfg_t                      cfg;
  logic [SAMPLE_FIELD_W-1:0] raw_ring [WINDOW_TAPS_DEF];
  logic [4:0]                raw_ptr;
  logic [SLOPE_W-1:0]        window_sum;
  logic [SLOPE_W-1:0]        sum_hist [HISTORY_DEPTH_DEF];
  logic [4:0]                hist_ptr;
  logic signed [LEVEL_W-1:0] lowest_lvl;
  logic signed [LEVEL_W-1:0] held_lvl;
  logic [CNT_W-1:0]          quiet_cnt;
  logic [CNT_W-1:0]          gap_cnt;
  logic [INTERVAL_W-1:0]     interval_cnt;
  logic                      second_phase;
  ppid_result_t              expected_results [$];
  int                        mismatches;

  task automatic rearm_tracker();
    lowest_lvl   = cfg.base_lvl;
    second_phase = 1'b0;
    gap_cnt      = '0;
    quiet_cnt    = '0;
    interval_cnt = '0;
  endtask

  task automatic predict_sample(input logic [SAMPLE_FIELD_W-1:0] smp, output ppid_result_t r);
    logic [SLOPE_W-1:0] old_sum;
    logic [SLOPE_W-1:0] slope;
    int                 lvl;
    r = '0;
    window_sum        = window_sum - raw_ring[raw_ptr] + smp;
    raw_ring[raw_ptr] = smp;
    raw_ptr           = (raw_ptr == WINDOW_TAPS_DEF - 1) ? '0 : raw_ptr + 1'b1;

    old_sum           = sum_hist[hist_ptr];
    slope             = (old_sum > window_sum) ? old_sum - window_sum : window_sum - old_sum;
    sum_hist[hist_ptr] = window_sum;
    hist_ptr          = (hist_ptr == HISTORY_DEPTH_DEF - 1) ? '0 : hist_ptr + 1'b1;

    if (quiet_cnt != CNT11_MAX) quiet_cnt = quiet_cnt + 1'b1;
    if (gap_cnt != CNT11_MAX) gap_cnt = gap_cnt + 1'b1;

    lvl = $signed(cfg.base_lvl);
    lvl = lvl - int'(slope / DIVISOR);
    if (lvl < -512) lvl = -512;
    if (lvl > 511) lvl = 511;

    if (quiet_cnt > cfg.timeout) begin
      rearm_tracker();
      r.noise_rearm = 1'b1;
    end else begin
      if (lvl < lowest_lvl) begin
        lowest_lvl = lvl[LEVEL_W-1:0];
        quiet_cnt  = '0;
        if (!second_phase) begin
          gap_cnt      = '0;
          interval_cnt = '0;
        end
      end
      if (gap_cnt > cfg.min_gap && !second_phase) begin
        held_lvl     = lowest_lvl;
        lowest_lvl   = cfg.rearm_lvl;
        gap_cnt      = '0;
        second_phase = 1'b1;
      end
      if (gap_cnt > cfg.min_gap && second_phase) begin
        r.beat_valid    = 1'b1;
        r.beat_interval = interval_cnt;
        r.beat_level    = held_lvl;
        held_lvl        = '0;
        rearm_tracker();
      end
    end

    if (interval_cnt != CNT16_MAX) interval_cnt = interval_cnt + 1'b1;
    r.slope = slope;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ppid_result_t want;
    ppid_result_t got;
    if (!rst_ni) begin
      cfg.min_gap   = MIN_GAP_RST;
      cfg.timeout   = TIMEOUT_RST;
      cfg.rearm_lvl = REARM_RST;
      cfg.base_lvl  = BASELINE_RST;
      for (int i = 0; i < WINDOW_TAPS_DEF; i++) raw_ring[i] = '0;
      for (int i = 0; i < HISTORY_DEPTH_DEF; i++) sum_hist[i] = '0;
      raw_ptr    = '0;
      hist_ptr   = '0;
      window_sum = '0;
      held_lvl   = '0;
      rearm_tracker();
      expected_results.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.slope         = m_axis_tdata[SLOPE_W-1:0];
        got.beat_interval = m_axis_tdata[SLOPE_W +: INTERVAL_W];
        got.beat_level    = m_axis_tdata[SLOPE_W+INTERVAL_W +: LEVEL_W];
        got.beat_valid    = m_axis_tuser[0];
        got.noise_rearm   = m_axis_tuser[1];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result without request: slope %0d beat %0b interval %0d level %0d noise %0b",
                     $time, got.slope, got.beat_valid, got.beat_interval,
                     $signed(got.beat_level), got.noise_rearm);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"%0t: mismatch: expected slope %0d beat %0b interval %0d level %0d",
                        " noise %0b, got slope %0d beat %0b interval %0d level %0d noise %0b"},
                       $time, want.slope, want.beat_valid, want.beat_interval,
                       $signed(want.beat_level), want.noise_rearm,
                       got.slope, got.beat_valid, got.beat_interval,
                       $signed(got.beat_level), got.noise_rearm);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_sample(s_axis_tdata[SAMPLE_FIELD_W-1:0], want);
        expected_results.push_back(want);
      end
      // register write lands at this edge, after the sample taken at the same edge
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MIN_GAP:  cfg.min_gap   = cfg_data_i[CNT_W-1:0];
          CFG_TIMEOUT:  cfg.timeout   = cfg_data_i[CNT_W-1:0];
          CFG_REARM:    cfg.rearm_lvl = cfg_data_i[LEVEL_W-1:0];
          CFG_BASELINE: cfg.base_lvl  = cfg_data_i[LEVEL_W-1:0];
          default: ;
        endcase
      end
      pending_o    <= expected_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

/* tb/sv/tb.sv */
// Testbench top for the pulse peak interval detector: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT   = 60000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 170;
  localparam int FLAT_ITEMS    = 180;
  localparam int IDLE_PCT      = 11;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [15:0]                     s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [47:0]                     m_axis_tdata;
  logic [1:0]                      m_axis_tuser;
  logic                            cfg_we_i      = 1'b0;
  logic [1:0]                      cfg_index_i   = '0;
  logic [ppid_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                            steady        = 1'b0;
  int                              pending;
  int                              fail_count;
  int                              cycle_count   = 0;

  pulse_peak_interval_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  ppid_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_sample(input logic [ppid_pkg::SAMPLE_FIELD_W-1:0] smp);
    int gap;
    gap = 0;
    if (!steady) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, smp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // all four registers in back-to-back writes; bit 10 of a level write is don't-care
  task automatic write_registers(input logic [ppid_pkg::CNT_W-1:0]   min_gap,
                                 input logic [ppid_pkg::CNT_W-1:0]   timeout,
                                 input logic [ppid_pkg::LEVEL_W-1:0] rearm_lvl,
                                 input logic [ppid_pkg::LEVEL_W-1:0] base_lvl);
    logic pad;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ppid_pkg::CFG_MIN_GAP;
    cfg_data_i  <= min_gap;
    @(posedge clk_i);
    cfg_index_i <= ppid_pkg::CFG_TIMEOUT;
    cfg_data_i  <= timeout;
    @(posedge clk_i);
    pad = 1'($urandom_range(1));
    cfg_index_i <= ppid_pkg::CFG_REARM;
    cfg_data_i  <= {pad, rearm_lvl};
    @(posedge clk_i);
    pad = 1'($urandom_range(1));
    cfg_index_i <= ppid_pkg::CFG_BASELINE;
    cfg_data_i  <= {pad, base_lvl};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [ppid_pkg::CNT_W-1:0] pick_count(input int span);
    logic [ppid_pkg::CNT_W-1:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = ppid_pkg::CNT11_MAX;
      default: v = ppid_pkg::CNT_W'($urandom_range(span));
    endcase
    return v;
  endfunction

  function automatic logic [ppid_pkg::LEVEL_W-1:0] pick_level();
    logic [ppid_pkg::LEVEL_W-1:0] v;
    case ($urandom_range(5))
      0:       v = 10'h200;
      1:       v = 10'h1FF;
      default: v = ppid_pkg::LEVEL_W'($urandom_range(1023));
    endcase
    return v;
  endfunction

  initial begin
    int                           period;
    int                           width;
    int                           lo;
    int                           hi;
    int                           smp;
    logic [ppid_pkg::LEVEL_W-1:0] rl;
    logic [ppid_pkg::LEVEL_W-1:0] bl;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers; full-scale run drives the slope to its top
    repeat (18) send_sample(12'hFFF);
    drain_results();
    // zero gap and zero timeout, levels at the top
    write_registers(11'd0, 11'd0, 10'h1FF, 10'h1FF);
    repeat (3) send_sample(12'h000);
    drain_results();
    // levels at the bottom, so the level clamps; timeout never expires
    write_registers(11'd0, ppid_pkg::CNT11_MAX, 10'h200, 10'h200);
    repeat (3) send_sample(12'h000);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      write_registers(pick_count(60), pick_count(400), pick_level(), pick_level());
      steady <= (ph == 3);
      period = $urandom_range(120, 15);
      width  = $urandom_range(30, 3);
      lo     = $urandom_range(1500);
      hi     = $urandom_range(4095, 2000);
      if ($urandom_range(3) == 0) begin
        lo = 0;
        hi = 4095;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 0 && k == PHASE_ITEMS / 2) drain_results();
        if ($urandom_range(99) < 12) smp = $urandom_range(4095);
        else smp = (((k % period) < width) ? hi : lo) ^ $urandom_range(7);
        send_sample(smp[ppid_pkg::SAMPLE_FIELD_W-1:0]);
      end
    end

    // flat input under the widest gap and timeout, then a short gap reports a beat
    drain_results();
    steady <= 1'b0;
    rl  = pick_level();
    bl  = pick_level();
    smp = $urandom_range(4095);
    write_registers(ppid_pkg::CNT11_MAX, ppid_pkg::CNT11_MAX, rl, bl);
    repeat (FLAT_ITEMS) send_sample(smp[ppid_pkg::SAMPLE_FIELD_W-1:0]);
    drain_results();
    write_registers(11'd5, ppid_pkg::CNT11_MAX, rl, bl);
    repeat (20) send_sample(smp[ppid_pkg::SAMPLE_FIELD_W-1:0]);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
